[rtl/core/outcome_history_failure_rate_assert.svh]
// Assertion macros for the checker of the outcome history block.
`ifndef OUTCOME_HISTORY_FAILURE_RATE_ASSERT_SVH
`define OUTCOME_HISTORY_FAILURE_RATE_ASSERT_SVH

// Checks a property at every rising clock edge outside of reset.
`define OHFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("outcome history check failed");

// Checks a property at every rising clock edge, reset included.
`define OHFR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("outcome history check failed");

`endif

[rtl/core/ohfr_pkg.sv]
// Shared constants and types of the outcome history failure rate block.
`timescale 1ns / 1ps
`default_nettype none

package ohfr_pkg;

  localparam int unsigned HISTORY_DEPTH = 1024;
  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);

  localparam int unsigned TYPE_W = 8;
  localparam int unsigned LAT_W = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned MATCH_W = 11;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned ENTRY_W = TYPE_W + 1;

  localparam int unsigned DIVD_W = LAT_W + 4;
  localparam int unsigned DIVCNT_W = $clog2(DIVD_W);

  localparam int unsigned AVG_DIV = 10;
  localparam logic [FRAC_W-1:0] HALF_Q16 = FRAC_W'(32768);

  // The average sum is divided by ten in two chunks by reciprocal multiplication.
  localparam int unsigned AVG_SPLIT = 16;
  localparam int unsigned AVG_HI_W = DIVD_W - AVG_SPLIT;
  localparam int unsigned AVG_QH_W = LAT_W - AVG_SPLIT;
  localparam int unsigned AVG_REM_W = 4;
  localparam int unsigned MUL_W = 2 * AVG_HI_W;
  localparam int unsigned AVG_RECIP = 838861;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned AVG_LAST_STEP = 2;

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_QUERY  = 1'b1
  } action_e;

endpackage

`default_nettype wire

[rtl/core/ohfr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ohfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/outcome_history_failure_rate.sv]
// Top level of the outcome history failure rate block.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a ring of the last 1024 request outcomes (type and success
// flag) in one RAM and takes one item at a time. A record is written, when
// learning is on, in the cycle it is accepted; its result then goes through
// the done state into the output register; when a nonzero running latency
// average is updated, it first goes through the average state, where the
// divide by ten is done by reciprocal multiplication. A query reads the
// filled slots one per cycle from the RAM port and then divides the failure
// count by the match count in a bit-serial divider of 36 steps; when nothing
// matches, also when the ring is empty, the divider is skipped. The input is
// stalled until the result is offered. A finished result waits in the
// output register while the next item is accepted. There is no clearing
// pass after reset, since only slots that were written are ever read.
module outcome_history_failure_rate (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic                            cfg_learning_on_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            in_action_i,
  input  wire logic [ohfr_pkg::TYPE_W-1:0]     in_req_type_i,
  input  wire logic [ohfr_pkg::LAT_W-1:0]      in_latency_us_i,
  input  wire logic                            in_succeeded_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [ohfr_pkg::MATCH_W-1:0]    out_match_count_o,
  output logic      [ohfr_pkg::MATCH_W-1:0]    out_match_failures_o,
  output logic      [ohfr_pkg::FRAC_W-1:0]     out_failure_fraction_o,
  output logic      [ohfr_pkg::LAT_W-1:0]      out_mean_latency_o,
  output logic      [ohfr_pkg::TOTAL_W-1:0]    out_ok_total_o,
  output logic      [ohfr_pkg::TOTAL_W-1:0]    out_fail_total_o
);

  import ohfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_AVG,
    ST_DONE
  } state_e;

  state_e               state_q, state_d;
  logic                 learn_q, learn_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [CNT_W-1:0]     filled_q, filled_d;
  logic [TOTAL_W-1:0]   ok_q, ok_d;
  logic [TOTAL_W-1:0]   fail_q, fail_d;
  logic [LAT_W-1:0]     avg_q, avg_d;
  logic [TYPE_W-1:0]    kind_q, kind_d;
  logic [CNT_W-1:0]     iss_q, iss_d;
  logic                 chk_q, chk_d;
  logic [CNT_W-1:0]     match_q, match_d;
  logic [CNT_W-1:0]     fails_q, fails_d;
  logic [FRAC_W-1:0]    frac_q, frac_d;
  logic [DIVD_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     div_q, div_d;
  logic [DIVCNT_W-1:0]  step_q, step_d;
  logic [AVG_QH_W-1:0]  avq_q, avq_d;
  logic [AVG_REM_W-1:0] avr_q, avr_d;
  logic                 ov_q, ov_d;
  logic [MATCH_W-1:0]   om_q, om_d;
  logic [MATCH_W-1:0]   of_q, of_d;
  logic [FRAC_W-1:0]    ofr_q, ofr_d;
  logic [LAT_W-1:0]     oa_q, oa_d;
  logic [TOTAL_W-1:0]   ook_q, ook_d;
  logic [TOTAL_W-1:0]   ofl_q, ofl_d;

  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 in_accept;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic [DIVD_W-1:0]    avg_sum;
  logic [AVG_HI_W-1:0]  mul_a;
  logic [MUL_W-1:0]     mul_p;

  ohfr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(ram_wdata),
    .raddr_i(iss_q[SLOT_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign ram_wdata = {in_req_type_i, in_succeeded_i};
  assign avg_sum = (DIVD_W'(avg_q) << 3) + DIVD_W'(avg_q) + DIVD_W'(in_latency_us_i);
  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign trial_ge = trial >= {1'b0, div_q};
  assign mul_a = (step_q == '0) ? quo_q[DIVD_W-1:AVG_SPLIT]
                                : {avr_q, quo_q[AVG_SPLIT-1:0]};
  assign mul_p = MUL_W'(mul_a) * MUL_W'(AVG_RECIP);

  always_comb begin
    state_d  = state_q;
    learn_d  = learn_q;
    slot_d   = slot_q;
    filled_d = filled_q;
    ok_d     = ok_q;
    fail_d   = fail_q;
    avg_d    = avg_q;
    kind_d   = kind_q;
    iss_d    = iss_q;
    chk_d    = chk_q;
    match_d  = match_q;
    fails_d  = fails_q;
    frac_d   = frac_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    div_d    = div_q;
    step_d   = step_q;
    avq_d    = avq_q;
    avr_d    = avr_q;
    ov_d     = ov_q;
    om_d     = om_q;
    of_d     = of_q;
    ofr_d    = ofr_q;
    oa_d     = oa_q;
    ook_d    = ook_q;
    ofl_d    = ofl_q;
    ram_we   = 1'b0;

    if (cfg_valid_i) begin
      learn_d = cfg_learning_on_i;
    end

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          match_d = '0;
          fails_d = '0;
          frac_d  = '0;
          if (action_e'(in_action_i) == ACT_QUERY) begin
            kind_d  = in_req_type_i;
            iss_d   = '0;
            chk_d   = 1'b0;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
            if (learn_q) begin
              ram_we = 1'b1;
              if (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) begin
                slot_d = '0;
              end else begin
                slot_d = slot_q + 1'b1;
              end
              if (filled_q != CNT_W'(HISTORY_DEPTH)) begin
                filled_d = filled_q + 1'b1;
              end
              if (in_succeeded_i) begin
                if (ok_q != '1) begin
                  ok_d = ok_q + 1'b1;
                end
              end else begin
                if (fail_q != '1) begin
                  fail_d = fail_q + 1'b1;
                end
              end
              if (avg_q == '0) begin
                avg_d = in_latency_us_i;
              end else begin
                quo_d   = avg_sum;
                step_d  = '0;
                state_d = ST_AVG;
              end
            end
          end
        end
      end

      ST_SCAN: begin
        if (chk_q && (ram_rdata[ENTRY_W-1:1] == kind_q)) begin
          match_d = match_q + 1'b1;
          if (!ram_rdata[0]) begin
            fails_d = fails_q + 1'b1;
          end
        end
        chk_d = iss_q < filled_q;
        if (iss_q < filled_q) begin
          iss_d = iss_q + 1'b1;
        end
        if (!chk_q && (iss_q == filled_q)) begin
          if (match_q == '0) begin
            frac_d  = HALF_Q16;
            state_d = ST_DONE;
          end else begin
            quo_d   = DIVD_W'(fails_q) << FRAC_SHIFT;
            rem_d   = '0;
            div_d   = match_q;
            step_d  = '0;
            state_d = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (trial_ge) begin
          rem_d = CNT_W'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[CNT_W-1:0];
        end
        quo_d  = {quo_q[DIVD_W-2:0], trial_ge};
        step_d = step_q + 1'b1;
        if (step_q == DIVCNT_W'(DIVD_W - 1)) begin
          frac_d  = quo_d[FRAC_W-1:0];
          state_d = ST_DONE;
        end
      end

      ST_AVG: begin
        step_d = step_q + 1'b1;
        if (step_q == '0) begin
          avq_d = mul_p[RECIP_SHIFT +: AVG_QH_W];
        end else if (step_q == DIVCNT_W'(AVG_LAST_STEP)) begin
          avg_d   = {avq_q, mul_p[RECIP_SHIFT +: AVG_SPLIT]};
          state_d = ST_DONE;
        end else begin
          avr_d = AVG_REM_W'(quo_q[DIVD_W-1:AVG_SPLIT]
                             - AVG_HI_W'(avq_q) * AVG_HI_W'(AVG_DIV));
        end
      end

      ST_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          om_d    = MATCH_W'(match_q);
          of_d    = MATCH_W'(fails_q);
          ofr_d   = frac_q;
          oa_d    = avg_q;
          ook_d   = ok_q;
          ofl_d   = fail_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      learn_q  <= 1'b1;
      slot_q   <= '0;
      filled_q <= '0;
      ok_q     <= '0;
      fail_q   <= '0;
      avg_q    <= '0;
      kind_q   <= '0;
      iss_q    <= '0;
      chk_q    <= 1'b0;
      match_q  <= '0;
      fails_q  <= '0;
      frac_q   <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      div_q    <= '0;
      step_q   <= '0;
      avq_q    <= '0;
      avr_q    <= '0;
      ov_q     <= 1'b0;
      om_q     <= '0;
      of_q     <= '0;
      ofr_q    <= '0;
      oa_q     <= '0;
      ook_q    <= '0;
      ofl_q    <= '0;
    end else begin
      state_q  <= state_d;
      learn_q  <= learn_d;
      slot_q   <= slot_d;
      filled_q <= filled_d;
      ok_q     <= ok_d;
      fail_q   <= fail_d;
      avg_q    <= avg_d;
      kind_q   <= kind_d;
      iss_q    <= iss_d;
      chk_q    <= chk_d;
      match_q  <= match_d;
      fails_q  <= fails_d;
      frac_q   <= frac_d;
      quo_q    <= quo_d;
      rem_q    <= rem_d;
      div_q    <= div_d;
      step_q   <= step_d;
      avq_q    <= avq_d;
      avr_q    <= avr_d;
      ov_q     <= ov_d;
      om_q     <= om_d;
      of_q     <= of_d;
      ofr_q    <= ofr_d;
      oa_q     <= oa_d;
      ook_q    <= ook_d;
      ofl_q    <= ofl_d;
    end
  end

  assign cfg_ready_o            = 1'b1;
  assign in_stall_o             = state_q != ST_IDLE;
  assign out_valid_o            = ov_q;
  assign out_match_count_o      = om_q;
  assign out_match_failures_o   = of_q;
  assign out_failure_fraction_o = ofr_q;
  assign out_mean_latency_o     = oa_q;
  assign out_ok_total_o         = ook_q;
  assign out_fail_total_o       = ofl_q;

endmodule

`default_nettype wire

[rtl/core/ohfr_checker.sv]
// Port-level checker of the outcome history block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "outcome_history_failure_rate_assert.svh"

module ohfr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_stall_i,
  input wire logic [ohfr_pkg::MATCH_W-1:0] match_count_i,
  input wire logic [ohfr_pkg::MATCH_W-1:0] match_failures_i,
  input wire logic [ohfr_pkg::FRAC_W-1:0]  failure_fraction_i
);

  // A result that is stalled stays offered.
  `OHFR_ASSERT(a_out_held, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i)

  // The block works on one item at a time, so an input transfer is followed by a stall.
  `OHFR_ASSERT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_i |=> in_stall_i)

  // Failures are a subset of the matches.
  `OHFR_ASSERT(a_fail_le_match, clk_i, rst_ni, out_valid_i |-> match_failures_i <= match_count_i)

  // Without matches the fraction is either zero for a record or one half for a query.
  `OHFR_ASSERT(a_no_match_frac, clk_i, rst_ni,
    out_valid_i && (match_count_i == '0) |->
    (failure_fraction_i == '0) || (failure_fraction_i == 17'd32768))

  // The fraction never exceeds one.
  `OHFR_ASSERT(a_frac_range, clk_i, rst_ni, out_valid_i |-> failure_fraction_i <= 17'd65536)

endmodule

bind outcome_history_failure_rate ohfr_checker u_ohfr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_i        (in_stall_o),
  .out_valid_i       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .match_count_i     (out_match_count_o),
  .match_failures_i  (out_match_failures_o),
  .failure_fraction_i(out_failure_fraction_o)
);

`default_nettype wire
